### rtl/sscs_pkg.sv
// Package for the sparse-set component store: field widths, codes, channel payloads.
// No dependencies; the top level refers to it by scoped names.
`default_nettype none

package sscs_pkg;

   localparam int ENTITY_W = 10;
   localparam int POSITION_W = 10;
   localparam int PAYLOAD_PORT_W = 64;
   localparam int COUNT_PORT_W = 11;
   localparam int OP_W = 2;
   localparam int STATUS_W = 2;

   localparam int MAX_ENTITIES_DEFAULT = 1024;
   localparam int PAYLOAD_WIDTH_DEFAULT = 64;

   typedef enum logic [OP_W-1:0] {
      OP_SET    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_GET    = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_ABSENT = 2'd1,
      ST_FULL   = 2'd2,
      ST_RANGE  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_FETCH,
      S_UNLINK
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic [ENTITY_W-1:0]       entity_id;
      logic [POSITION_W-1:0]     dense_position;
      logic [PAYLOAD_PORT_W-1:0] payload_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic                      present;
      logic [PAYLOAD_PORT_W-1:0] payload_out;
      logic [ENTITY_W-1:0]       entity_out;
      logic [POSITION_W-1:0]     slot;
      logic [COUNT_PORT_W-1:0]   entry_count;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/sscs_stream_if.sv
// Valid/ready channel carrying one payload struct per transfer.
// Payload type is handed in by the instantiating level (see sscs_pkg).
`default_nettype none

interface sscs_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/sscs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the sparse map and the dense entry array.
`default_nettype none

module sscs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/sparse_set_component_store.sv
// Top level of the sparse-set component store: sequencer, entry count, response register.
// Uses sscs_pkg, sscs_stream_if and two sscs_ram instances (sparse map, dense entries).
//
//   channel | direction | payload              | transfer when
//   --------+-----------+----------------------+--------------------------
//   req_if  | in        | sscs_pkg::req_type   | req_if.valid & req_if.ready
//   rsp_if  | out       | sscs_pkg::rsp_type   | rsp_if.valid & rsp_if.ready
//
// Set, read-at and a get or remove of an absent entity answer from the lookup step;
// a get or remove that hits goes on to FETCH or UNLINK: each needs a map read, then get
// re-reads the dense RAM and remove needs a second map write.
// After reset the sparse map is cleared one entry a cycle, all MAX_ENTITIES entries,
// with req_if.ready low. One request is in flight at a time; its result waits in
// the response register while the next request is accepted, and the sequencer
// holds its last step while that register is still occupied.
`default_nettype none

module sparse_set_component_store #(
   parameter int MAX_ENTITIES  = sscs_pkg::MAX_ENTITIES_DEFAULT,
   parameter int PAYLOAD_WIDTH = sscs_pkg::PAYLOAD_WIDTH_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   sscs_stream_if.sink   req_if,
   sscs_stream_if.source rsp_if
);

   localparam int IDX_W   = $clog2(MAX_ENTITIES);
   localparam int CNT_W   = $clog2(MAX_ENTITIES + 1);
   localparam int MAP_W   = IDX_W + 1;
   localparam int DENSE_W = sscs_pkg::ENTITY_W + PAYLOAD_WIDTH;

   sscs_pkg::state_type state_ff, state_in;

   logic [sscs_pkg::OP_W-1:0]       op_ff;
   logic [sscs_pkg::ENTITY_W-1:0]   eid_ff;
   logic [sscs_pkg::POSITION_W-1:0] dpos_ff;
   logic [PAYLOAD_WIDTH-1:0]        data_ff;
   logic [IDX_W-1:0]                pos_ff, pos_in;
   logic [IDX_W-1:0]                clr_ff, clr_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   sscs_pkg::rsp_type               rsp_ff, rsp_in;
   logic                            load_rsp;

   logic               map_we;
   logic [IDX_W-1:0]   map_waddr, map_raddr;
   logic [MAP_W-1:0]   map_wdata, map_rdata;
   logic               dense_we;
   logic [IDX_W-1:0]   dense_waddr, dense_raddr;
   logic [DENSE_W-1:0] dense_wdata, dense_rdata;

   logic                          req_fire;
   logic                          out_free;
   logic                          map_valid;
   logic [IDX_W-1:0]              map_pos;
   logic                          in_map;
   logic                          has;
   logic                          full;
   logic                          in_range;
   logic [IDX_W-1:0]              last_idx;
   logic [sscs_pkg::ENTITY_W-1:0] dense_id;
   logic [PAYLOAD_WIDTH-1:0]      dense_pay;

   sscs_ram #(.WIDTH(MAP_W), .DEPTH(MAX_ENTITIES)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   sscs_ram #(.WIDTH(DENSE_W), .DEPTH(MAX_ENTITIES)) u_dense (
      .clock   (clock),
      .wr_en   (dense_we),
      .wr_addr (dense_waddr),
      .wr_data (dense_wdata),
      .rd_addr (dense_raddr),
      .rd_data (dense_rdata)
   );

   assign req_if.ready = (state_ff == sscs_pkg::S_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // map entry: valid bit over dense position
   assign map_valid = map_rdata[MAP_W-1];
   assign map_pos   = map_rdata[IDX_W-1:0];
   assign in_map    = 32'(eid_ff) < MAX_ENTITIES;
   assign has       = in_map && map_valid && (CNT_W'(map_pos) < count_ff);
   assign full      = count_ff == CNT_W'(MAX_ENTITIES);
   assign in_range  = 32'(dpos_ff) < 32'(count_ff);
   assign last_idx  = IDX_W'(count_ff - CNT_W'(1));
   assign dense_id  = dense_rdata[DENSE_W-1 -: sscs_pkg::ENTITY_W];
   assign dense_pay = dense_rdata[PAYLOAD_WIDTH-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sscs_pkg::S_CLEAR: begin
            if (clr_ff == IDX_W'(MAX_ENTITIES - 1)) state_in = sscs_pkg::S_IDLE;
         end
         sscs_pkg::S_IDLE: begin
            if (req_fire) state_in = sscs_pkg::S_LOOKUP;
         end
         sscs_pkg::S_LOOKUP: begin
            case (op_ff)
               sscs_pkg::OP_GET: begin
                  if (has) state_in = sscs_pkg::S_FETCH;
                  else if (out_free) state_in = sscs_pkg::S_IDLE;
               end
               sscs_pkg::OP_REMOVE: begin
                  if (has) state_in = sscs_pkg::S_UNLINK;
                  else if (out_free) state_in = sscs_pkg::S_IDLE;
               end
               default: begin
                  if (out_free) state_in = sscs_pkg::S_IDLE;
               end
            endcase
         end
         sscs_pkg::S_FETCH, sscs_pkg::S_UNLINK: begin
            if (out_free) state_in = sscs_pkg::S_IDLE;
         end
         default: state_in = sscs_pkg::S_IDLE;
      endcase
   end

   // memory controls, count update and response; writes of a responding step
   // wait with it until the response register is free, so a held step repeats
   // only reads of unchanged entries
   always_comb begin
      map_we      = 1'b0;
      map_waddr   = IDX_W'(eid_ff);
      map_wdata   = '0;
      map_raddr   = IDX_W'(eid_ff);
      dense_we    = 1'b0;
      dense_waddr = map_pos;
      dense_wdata = {eid_ff, data_ff};
      dense_raddr = last_idx;
      count_in    = count_ff;
      pos_in      = pos_ff;
      clr_in      = clr_ff;
      load_rsp    = 1'b0;
      rsp_in      = '0;

      case (state_ff)
         sscs_pkg::S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            clr_in    = clr_ff + IDX_W'(1);
         end
         sscs_pkg::S_IDLE: begin
            map_raddr = IDX_W'(req_if.payload.entity_id);
            if (req_if.payload.operation == sscs_pkg::OP_READ) begin
               dense_raddr = IDX_W'(req_if.payload.dense_position);
            end
         end
         sscs_pkg::S_LOOKUP: begin
            pos_in         = map_pos;
            rsp_in.present = has;
            rsp_in.slot    = sscs_pkg::POSITION_W'(map_pos);
            case (op_ff)
               sscs_pkg::OP_SET: begin
                  load_rsp = out_free;
                  if (!in_map) begin
                     rsp_in.status = sscs_pkg::ST_ABSENT;
                     rsp_in.slot   = '0;
                  end else if (has) begin
                     dense_we = out_free;
                  end else if (full) begin
                     rsp_in.status = sscs_pkg::ST_FULL;
                     rsp_in.slot   = '0;
                  end else begin
                     dense_we    = out_free;
                     dense_waddr = IDX_W'(count_ff);
                     map_we      = out_free;
                     map_wdata   = {1'b1, IDX_W'(count_ff)};
                     if (out_free) count_in = count_ff + CNT_W'(1);
                     rsp_in.slot = sscs_pkg::POSITION_W'(count_ff);
                  end
               end
               sscs_pkg::OP_REMOVE: begin
                  if (has) begin
                     // last entry moves into the freed slot; its owner is repointed
                     dense_we    = 1'b1;
                     dense_wdata = dense_rdata;
                     map_we      = 1'b1;
                     map_waddr   = IDX_W'(dense_id);
                     map_wdata   = {1'b1, map_pos};
                     count_in    = count_ff - CNT_W'(1);
                  end else begin
                     load_rsp      = out_free;
                     rsp_in.status = sscs_pkg::ST_ABSENT;
                     rsp_in.slot   = '0;
                  end
               end
               sscs_pkg::OP_GET: begin
                  dense_raddr = map_pos;
                  if (!has) begin
                     load_rsp      = out_free;
                     rsp_in.status = sscs_pkg::ST_ABSENT;
                     rsp_in.slot   = '0;
                  end
               end
               default: begin
                  dense_raddr = IDX_W'(dpos_ff);
                  load_rsp    = out_free;
                  if (in_range) begin
                     rsp_in.present     = 1'b1;
                     rsp_in.entity_out  = dense_id;
                     rsp_in.payload_out = sscs_pkg::PAYLOAD_PORT_W'(dense_pay);
                     rsp_in.slot        = dpos_ff;
                  end else begin
                     rsp_in.status  = sscs_pkg::ST_RANGE;
                     rsp_in.present = 1'b0;
                     rsp_in.slot    = '0;
                  end
               end
            endcase
         end
         sscs_pkg::S_FETCH: begin
            dense_raddr        = pos_ff;
            load_rsp           = out_free;
            rsp_in.present     = 1'b1;
            rsp_in.payload_out = sscs_pkg::PAYLOAD_PORT_W'(dense_pay);
            rsp_in.slot        = sscs_pkg::POSITION_W'(pos_ff);
         end
         sscs_pkg::S_UNLINK: begin
            // after the repoint, so removing the last entry still ends invalid
            map_we         = out_free;
            load_rsp       = out_free;
            rsp_in.present = 1'b1;
            rsp_in.slot    = sscs_pkg::POSITION_W'(pos_ff);
         end
         default: begin
            load_rsp = 1'b0;
         end
      endcase

      rsp_in.entry_count = sscs_pkg::COUNT_PORT_W'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_if.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sscs_pkg::S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_if.payload.operation;
         eid_ff  <= req_if.payload.entity_id;
         dpos_ff <= req_if.payload.dense_position;
         data_ff <= PAYLOAD_WIDTH'(req_if.payload.payload_in);
      end
      pos_ff <= pos_in;
      if (load_rsp) rsp_ff <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTITIES))
      else $error("entry count above capacity");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("response register overwritten");

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == sscs_pkg::S_LOOKUP)
      else $error("accepted request not looked up");

   a_unlink_after_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sscs_pkg::S_UNLINK) |->
         ($past(state_ff) == sscs_pkg::S_LOOKUP || $past(state_ff) == sscs_pkg::S_UNLINK))
      else $error("unlink step entered out of order");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sscs_pkg::S_LOOKUP && op_ff == sscs_pkg::OP_REMOVE && has)
         |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("remove did not drop the entry count");

endmodule

`default_nettype wire
